// ===== sv/ttt_pkg.sv =====
`timescale 1ns / 1ps
package ttt_pkg;
   localparam int NUM_SLOTS_DEF = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0, OP_ADD = 2'd1, OP_RM_CB = 2'd2, OP_RM_ALL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_FIRED = 3'd0, KIND_ADDED = 3'd1, KIND_FULL = 3'd2,
      KIND_MALFORMED = 3'd3, KIND_REMOVED = 3'd4
   } kind_type;

   localparam int F_ABS = 0;
   localparam int F_OFS = 1;
   localparam int F_RPT = 2;
   localparam int F_1HZ = 3;
   localparam int F_FROM_DUE = 4;
   localparam int F_FROM_NOW = 5;
   localparam int F_ARG = 6;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] now_seconds;
      logic [31:0] time_value;
      logic [31:0] repeat_interval;
      logic [6:0]  mode_flags;
      logic [15:0] callback_id;
      logic [15:0] arg_id;
      logic [7:0]  user_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot_index;
      logic [15:0] fired_callback;
      logic [15:0] fired_arg;
      logic        pass_arg;
      logic [4:0]  removed_count;
      logic        last;
   } rsp_type;

   // one stored task, all fields in one memory word
   typedef struct packed {
      logic [31:0] due;
      logic [31:0] interval;
      logic [6:0]  flags;
      logic [15:0] cb;
      logic [15:0] arg;
      logic [7:0]  user;
   } entry_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? TIME_MAX : s[31:0];
   endfunction
endpackage

// ===== sv/ttt_req_if.sv =====
`timescale 1ns / 1ps
interface ttt_req_if;
   import ttt_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ttt_rsp_if.sv =====
`timescale 1ns / 1ps
interface ttt_rsp_if;
   import ttt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/ttt_store.sv =====
`timescale 1ns / 1ps
module ttt_store #(
   parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                clock,
   input  logic [IW-1:0]       rd_addr,
   output ttt_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  ttt_pkg::entry_type  wr_data
);
   import ttt_pkg::*;

   entry_type mem [NUM_SLOTS];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== sv/timed_task_table.sv =====
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | op, now_seconds, time_value, repeat_interval, mode_flags, ids
// rsp     | out | kind, slot_index, fired_callback, fired_arg, pass_arg, count, last
// csr     | in  | full_policy (write only)
// one transaction at a time. tick and remove walk the slot memory one slot a
// cycle while no output stall holds them, reading each slot through the registered
// memory read. a tick on a repeated second does not walk. reset clears valid bits,
// last tick second and full_policy; the memory needs no clearing. a stalled result
// holds the walk at the next due slot.
module timed_task_table #(
   parameter int NUM_SLOTS = ttt_pkg::NUM_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ttt_req_if.sink    req,
   ttt_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic       csr_wdata
);
   import ttt_pkg::*;

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_WALK = 4'b0010, ST_OUT = 4'b0100, ST_LAST = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   req_type             cur_ff, cur_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [31:0]         last_tick_ff, last_tick_in;
   logic                policy_ff;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IW:0]         cnt_ff, cnt_in;
   logic [CW-1:0]       fired_ff, fired_in;
   logic                hold_ff, hold_in;
   rsp_type             hold_data_ff, hold_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [IW-1:0] rd_addr;
   entry_type     rd_data, wr_data;
   logic          wr_en;
   logic [IW-1:0] wr_addr;

   ttt_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
      .clock(clock), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   assign req.ready   = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   logic          out_free;
   logic [IW-1:0] free_slot;
   logic          have_free;
   logic          due_hit, rm_hit;
   logic [31:0]   new_due;
   entry_type     upd;
   logic          keep;
   logic          idx_last;
   logic [31:0]   add_due;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign idx_last = (idx_ff == IW'(NUM_SLOTS - 1));

   // first free slot search over valid bits
   always_comb begin
      free_slot = '0;
      have_free = 1'b0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_slot = IW'(i);
            have_free = 1'b1;
         end
      end
   end

   // per slot evaluation of the entry read last cycle, and the due time of a new add
   always_comb begin
      due_hit = valid_ff[idx_ff] && (rd_data.due <= cur_ff.now_seconds);
      rm_hit  = valid_ff[idx_ff] && (rd_data.cb == cur_ff.callback_id) &&
                ((cur_ff.op != OP_RM_ALL) ||
                 (rd_data.user == cur_ff.user_id && rd_data.arg == cur_ff.arg_id));
      upd  = rd_data;
      keep = rd_data.flags[F_RPT];
      new_due = rd_data.due;
      if (rd_data.flags[F_1HZ]) begin
         new_due = rd_data.due;
      end else if (rd_data.interval == 32'd1) begin
         upd.flags[F_1HZ] = 1'b1;
      end else if (rd_data.flags[F_FROM_DUE]) begin
         new_due = sat_add(rd_data.due, rd_data.interval);
      end else if (rd_data.flags[F_FROM_NOW]) begin
         new_due = sat_add(cur_ff.now_seconds, rd_data.interval);
      end
      upd.due = new_due;
      add_due = req.payload.mode_flags[F_ABS] ? req.payload.time_value :
                sat_add(req.payload.now_seconds, req.payload.time_value);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      valid_in     = valid_ff;
      last_tick_in = last_tick_ff;
      idx_in       = idx_ff;
      rd_pend_in   = 1'b0;
      cnt_in       = cnt_ff;
      fired_in     = fired_ff;
      hold_in      = hold_ff;
      hold_data_in = hold_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = upd;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cur_in   = req.payload;
               idx_in   = '0;
               cnt_in   = '0;
               fired_in = '0;
               hold_in  = 1'b0;
               rd_addr  = '0;
               rsp_data_in = '0;
               rsp_data_in.last = 1'b1;
               priority if (req.payload.op == OP_TICK) begin
                  if (req.payload.now_seconds != last_tick_ff) begin
                     last_tick_in = req.payload.now_seconds;
                     rd_pend_in   = 1'b1;
                     state_in     = ST_WALK;
                  end
               end else if (req.payload.op == OP_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (!req.payload.mode_flags[F_ABS] && !req.payload.mode_flags[F_OFS]) begin
                     rsp_data_in.kind = KIND_MALFORMED;
                  end else if (!have_free && !policy_ff) begin
                     rsp_data_in.kind = KIND_FULL;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = have_free ? free_slot : IW'(NUM_SLOTS - 1);
                     wr_data.due      = add_due;
                     wr_data.interval = req.payload.mode_flags[F_RPT] ?
                                        req.payload.repeat_interval : 32'd0;
                     wr_data.flags    = req.payload.mode_flags;
                     wr_data.cb       = req.payload.callback_id;
                     wr_data.arg      = req.payload.arg_id;
                     wr_data.user     = req.payload.user_id;
                     valid_in[wr_addr] = 1'b1;
                     rsp_data_in.kind  = KIND_ADDED;
                     rsp_data_in.slot_index = 4'(wr_addr);
                  end
               end else begin
                  rd_pend_in = 1'b1;
                  state_in   = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // rd_data holds slot idx_ff when rd_pend_ff
            if (rd_pend_ff) begin
               if (cur_ff.op == OP_TICK) begin
                  if (due_hit && (fired_ff != CW'(MAX_RESULTS))) begin
                     if (!hold_ff || out_free) begin
                        // emit previous held fire, hold this one
                        if (hold_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_data_in  = hold_data_ff;
                        end
                        hold_in = 1'b1;
                        hold_data_in = '0;
                        hold_data_in.kind = KIND_FIRED;
                        hold_data_in.slot_index = 4'(idx_ff);
                        hold_data_in.fired_callback = rd_data.cb;
                        hold_data_in.fired_arg = rd_data.arg;
                        hold_data_in.pass_arg = rd_data.flags[F_ARG];
                        fired_in = fired_ff + CW'(1);
                        if (keep) begin
                           wr_en = 1'b1;
                        end else begin
                           valid_in[idx_ff] = 1'b0;
                        end
                        if (idx_last) state_in = ST_LAST;
                        else begin
                           idx_in = idx_ff + IW'(1);
                           rd_addr = idx_in;
                           rd_pend_in = 1'b1;
                        end
                     end else begin
                        rd_pend_in = 1'b1;
                     end
                  end else begin
                     if (idx_last) state_in = ST_LAST;
                     else begin
                        idx_in = idx_ff + IW'(1);
                        rd_addr = idx_in;
                        rd_pend_in = 1'b1;
                     end
                  end
               end else begin
                  if (rm_hit) begin
                     valid_in[idx_ff] = 1'b0;
                     cnt_in = cnt_ff + (IW+1)'(1);
                  end
                  if (idx_last) state_in = ST_OUT;
                  else begin
                     idx_in = idx_ff + IW'(1);
                     rd_addr = idx_in;
                     rd_pend_in = 1'b1;
                  end
               end
            end else begin
               rd_pend_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in.kind = KIND_REMOVED;
               rsp_data_in.removed_count = 5'(cnt_ff);
               rsp_data_in.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_LAST: begin
            if (!hold_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = hold_data_ff;
               rsp_data_in.last = 1'b1;
               hold_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         last_tick_ff <= '0;
         policy_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hold_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         last_tick_ff <= last_tick_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         rd_pend_ff   <= rd_pend_in;
         if (csr_we) policy_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
      fired_ff     <= fired_in;
      hold_data_ff <= hold_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // checks
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");
   a_hold_walk: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (state_ff == ST_WALK || state_ff == ST_LAST))
      else $error("held fire outside tick walk");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.payload))
      else $error("result changed under stall");
endmodule

// ===== test/tb_timed_task_table.sv =====
`timescale 1ns / 1ps
module tb_timed_task_table;
   import ttt_pkg::*;

   localparam int SLOTS = NUM_SLOTS_DEF;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   ttt_req_if req ();
   ttt_rsp_if rsp ();

   timed_task_table uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // shadow of the task table
   logic      full_policy_sh;
   logic      sh_valid [SLOTS];
   entry_type sh_entry [SLOTS];
   logic [31:0] sh_last_tick;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int errors;
   int accepted;
   int checked;
   int fired_seen;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_off_cycles;

   // 32 bit saturating sum for due time updates
   function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic rsp_type make_rsp(kind_type k, logic [3:0] slot, logic [4:0] cnt);
      rsp_type r;
      r = '0;
      r.kind = k;
      r.slot_index = slot;
      r.removed_count = cnt;
      r.last = 1'b1;
      return r;
   endfunction

   // work out the results of one accepted transaction and update the shadow
   task automatic predict_table(input req_type t);
      rsp_type r;
      int      n;
      int      slot;
      int      cnt;
      logic [31:0] due;
      logic    hit;
      logic [6:0] f;
      n = 0;
      cnt = 0;
      slot = SLOTS;
      case (op_type'(t.op))
         OP_TICK: begin
            if (t.now_seconds != sh_last_tick) begin
               sh_last_tick = t.now_seconds;
               for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
                  if (sh_valid[i] && sh_entry[i].due <= t.now_seconds) begin
                     r = '0;
                     r.kind = KIND_FIRED;
                     r.slot_index = i[3:0];
                     r.fired_callback = sh_entry[i].cb;
                     r.fired_arg = sh_entry[i].arg;
                     r.pass_arg = sh_entry[i].flags[F_ARG];
                     expected_rsps.push_back(r);
                     n++;
                     f = sh_entry[i].flags;
                     if (!f[F_RPT]) sh_valid[i] = 1'b0;
                     else if (f[F_1HZ]) ;
                     else if (sh_entry[i].interval == 32'd1) sh_entry[i].flags[F_1HZ] = 1'b1;
                     else if (f[F_FROM_DUE])
                        sh_entry[i].due = clamp_add(sh_entry[i].due, sh_entry[i].interval);
                     else if (f[F_FROM_NOW])
                        sh_entry[i].due = clamp_add(t.now_seconds, sh_entry[i].interval);
                  end
               end
               if (n > 0) begin
                  r = expected_rsps.pop_back();
                  r.last = 1'b1;
                  expected_rsps.push_back(r);
               end
            end
         end
         OP_ADD: begin
            if (!t.mode_flags[F_ABS] && !t.mode_flags[F_OFS]) begin
               expected_rsps.push_back(make_rsp(KIND_MALFORMED, 4'd0, 5'd0));
            end else begin
               due = t.mode_flags[F_ABS] ? t.time_value
                                         : clamp_add(t.now_seconds, t.time_value);
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!sh_valid[i]) slot = i;
               if (slot >= SLOTS && !full_policy_sh) begin
                  expected_rsps.push_back(make_rsp(KIND_FULL, 4'd0, 5'd0));
               end else begin
                  if (slot >= SLOTS) slot = SLOTS - 1;
                  sh_valid[slot] = 1'b1;
                  sh_entry[slot].due = due;
                  sh_entry[slot].interval = t.mode_flags[F_RPT] ? t.repeat_interval : 32'd0;
                  sh_entry[slot].flags = t.mode_flags;
                  sh_entry[slot].cb = t.callback_id;
                  sh_entry[slot].arg = t.arg_id;
                  sh_entry[slot].user = t.user_id;
                  expected_rsps.push_back(make_rsp(KIND_ADDED, slot[3:0], 5'd0));
               end
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (sh_valid[i]) begin
                  hit = sh_entry[i].cb == t.callback_id;
                  if (op_type'(t.op) == OP_RM_ALL)
                     hit = hit && sh_entry[i].user == t.user_id && sh_entry[i].arg == t.arg_id;
                  if (hit) begin
                     sh_valid[i] = 1'b0;
                     cnt++;
                  end
               end
            end
            expected_rsps.push_back(make_rsp(KIND_REMOVED, 4'd0, cnt[4:0]));
         end
      endcase
   endtask

   // small id pools so removals find matches
   function automatic req_type rand_item(logic [31:0] now);
      req_type t;
      int sel;
      t.op = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      t.now_seconds = (sel == 0) ? $urandom : now;
      t.time_value = (sel < 2) ? $urandom : 32'($urandom_range(0, 12));
      t.repeat_interval = (sel == 3) ? $urandom : 32'($urandom_range(0, 5));
      t.mode_flags = 7'($urandom);
      t.callback_id = (sel == 4) ? 16'($urandom) : 16'($urandom_range(0, 5));
      t.arg_id = (sel == 5) ? 16'($urandom) : 16'($urandom_range(0, 3));
      t.user_id = (sel == 6) ? 8'($urandom) : 8'($urandom_range(0, 3));
      return t;
   endfunction

   function automatic req_type item(op_type op, logic [31:0] now, logic [31:0] tv,
                                    logic [31:0] iv, logic [6:0] fl, logic [15:0] cb,
                                    logic [15:0] arg, logic [7:0] user);
      req_type t;
      t.op = op;
      t.now_seconds = now;
      t.time_value = tv;
      t.repeat_interval = iv;
      t.mode_flags = fl;
      t.callback_id = cb;
      t.arg_id = arg;
      t.user_id = user;
      return t;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // driver: offers the head of the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            predict_table(pending_reqs.pop_front());
            accepted++;
         end
         if ((!req.valid || req.ready) ) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req.valid <= 1'b1;
               req.payload <= pending_reqs[0];
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            a = rsp.payload;
            checked++;
            if (a.kind == KIND_FIRED) fired_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, a);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (a !== e) begin
                  $display("%0t: expected %p actual %p", $time, e, a);
                  errors++;
               end
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic drain_all();
      while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_policy(logic v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      full_policy_sh = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int count, int idle, int stall, inout logic [31:0] now);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) now = now + 32'($urandom_range(0, 3));
         pending_reqs.push_back(rand_item(now));
      end
      drain_all();
   endtask

   // stimulus
   initial begin
      logic [31:0] now;
      errors = 0;
      accepted = 0;
      checked = 0;
      fired_seen = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      full_policy_sh = 1'b0;
      sh_last_tick = '0;
      for (int i = 0; i < SLOTS; i++) begin
         sh_valid[i] = 1'b0;
         sh_entry[i] = '0;
      end
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_policy(1'b0);

      // directed: repeated second at zero, malformed, all repeat rules, overflow
      pending_reqs.push_back(item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_ADD, 5, 1, 0, 7'h00, 1, 1, 1));
      pending_reqs.push_back(item(OP_ADD, 5, 0, 0, 7'h41, 16'h0000, 16'hFFFF, 8'hFF));
      pending_reqs.push_back(item(OP_ADD, 5, 2, 1, 7'h06, 2, 2, 2));
      pending_reqs.push_back(item(OP_ADD, 5, 3, 4, 7'h15, 3, 3, 3));
      pending_reqs.push_back(item(OP_ADD, 5, 1, 9, 7'h26, 4, 4, 4));
      pending_reqs.push_back(item(OP_ADD, 5, 2, 7, 7'h0D, 5, 5, 5));
      pending_reqs.push_back(item(OP_ADD, 5, 1, 7, 7'h05, 16'hFFFF, 0, 0));
      pending_reqs.push_back(item(OP_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  7'h7F, 6, 6, 6));
      pending_reqs.push_back(item(OP_TICK, 6, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_TICK, 6, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_TICK, 9, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_TICK, 15, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(item(OP_RM_ALL, 0, 0, 0, 0, 4, 4, 4));
      pending_reqs.push_back(item(OP_RM_CB, 0, 0, 0, 0, 16'h7777, 0, 0));
      for (int i = 0; i < 8; i++)
         pending_reqs.push_back(item(OP_ADD, 0, 100, 0, 7'h02, 16'(i), 0, 0));
      drain_all();
      pending_reqs.push_back(item(OP_ADD, 0, 1, 0, 7'h01, 9, 9, 9));
      pending_reqs.push_back(item(OP_ADD, 0, 1, 0, 7'h01, 9, 9, 9));
      drain_all();

      // overwrite of the last slot when full
      write_policy(1'b1);
      pending_reqs.push_back(item(OP_ADD, 0, 1, 0, 7'h01, 10, 10, 10));
      pending_reqs.push_back(item(OP_TICK, 16, 0, 0, 0, 0, 0, 0));
      drain_all();

      now = 20;
      random_phase(100, 0, 0, now);
      write_policy(1'b0);
      random_phase(100, 46, 0, now);
      write_policy(1'b1);
      random_phase(100, 0, 46, now);

      // long receiver hold-off while the sender keeps offering
      hold_off_cycles = 400;
      random_phase(100, 17, 17, now);
      write_policy(1'b0);
      random_phase(20, 0, 0, now);

      $display("run covered %0d transactions in, %0d results (%0d task firings)",
               accepted, checked, fired_seen);
      $display("both full policies, repeat rules, removals, idle and stall phases");
      if (errors == 0 && expected_rsps.size() == 0)
         $display("timed_task_table: match");
      else
         $display("timed_task_table: mismatch");
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("timed_task_table: mismatch");
      $finish;
   end
endmodule
